@@ sv/ldts_pkg.sv @@
package ldts_pkg;

    localparam int YEAR_W   = 17;
    localparam int SMALL_W  = 7;
    localparam int YEAR_MAX = 99999;
    localparam int YEAR_LIM = YEAR_MAX + 1;

    localparam logic [2:0] PH_HUNT  = 3'd0;
    localparam logic [2:0] PH_DAY   = 3'd1;
    localparam logic [2:0] PH_MPRE  = 3'd2;
    localparam logic [2:0] PH_MSIGN = 3'd3;
    localparam logic [2:0] PH_MDIG  = 3'd4;
    localparam logic [2:0] PH_YPRE  = 3'd5;
    localparam logic [2:0] PH_YSIGN = 3'd6;
    localparam logic [2:0] PH_YDIG  = 3'd7;

    localparam logic [SMALL_W-1:0] SMALL_SAT = 7'd127;
    localparam logic [SMALL_W-1:0] DAY_MAX   = 7'd31;
    localparam logic [SMALL_W-1:0] MONTH_MAX = 7'd12;

    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef struct packed {
        logic [2:0]         phase;
        logic               neg;
        logic [SMALL_W-1:0] day;
        logic [SMALL_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } scan_t;

    localparam scan_t SCAN_RESET = '{phase: PH_HUNT, neg: 1'b0, day: '0, month: '0, year: '0};

    function automatic logic [SMALL_W-1:0] acc_small(input logic [SMALL_W-1:0] acc,
                                                     input logic [3:0] d);
        logic [SMALL_W+3:0] v;
        v = {4'b0, acc} * 11'd10 + {7'b0, d};
        if (v > {4'b0, SMALL_SAT})
            return SMALL_SAT;
        return v[SMALL_W-1:0];
    endfunction

    function automatic logic [YEAR_W-1:0] acc_year(input logic [YEAR_W-1:0] acc,
                                                   input logic [3:0] d);
        logic [YEAR_W+3:0] v;
        v = {4'b0, acc} * (YEAR_W+4)'(10) + {(YEAR_W)'(0), d};
        if (v > (YEAR_W+4)'(YEAR_LIM))
            return (YEAR_W)'(YEAR_LIM);
        return v[YEAR_W-1:0];
    endfunction

    function automatic logic year_ok(input logic neg, input logic [YEAR_W-1:0] year);
        return !neg && (year != '0) && (year <= (YEAR_W)'(YEAR_MAX));
    endfunction

endpackage

@@ sv/ldts_parse.sv @@
module ldts_parse
    import ldts_pkg::*;
(
    input  logic [7:0] ch,
    input  logic       last,
    input  scan_t      cur,
    output scan_t      nxt,
    output logic       found
);

    logic       is_dig;
    logic       is_sp;
    logic       is_sign;
    logic [7:0] diff;
    logic [3:0] digit;

    assign is_dig  = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign is_sp   = ((ch >= CH_TAB) && (ch <= CH_CR)) || (ch == CH_SPACE);
    assign is_sign = (ch == CH_PLUS) || (ch == CH_MINUS);
    assign diff    = ch - CH_ZERO;
    assign digit   = diff[3:0];

    always_comb
    begin
        nxt   = cur;
        found = 1'b0;
        unique case (cur.phase)
            PH_HUNT:
            begin
                if (is_dig)
                begin
                    nxt.day   = {3'b0, digit};
                    nxt.phase = PH_DAY;
                end
            end
            PH_DAY:
            begin
                if (is_dig)
                    nxt.day = acc_small(cur.day, digit);
                else if (ch == CH_DOT && cur.day != '0 && cur.day <= DAY_MAX)
                begin
                    nxt.phase = PH_MPRE;
                    nxt.neg   = 1'b0;
                    nxt.month = '0;
                end
                else
                    nxt.phase = PH_HUNT;
            end
            PH_MPRE, PH_YPRE:
            begin
                if (!is_sp)
                begin
                    if (is_sign)
                    begin
                        nxt.neg   = (ch == CH_MINUS);
                        nxt.phase = (cur.phase == PH_MPRE) ? PH_MSIGN : PH_YSIGN;
                    end
                    else if (is_dig)
                    begin
                        if (cur.phase == PH_MPRE)
                        begin
                            nxt.month = {3'b0, digit};
                            nxt.phase = PH_MDIG;
                        end
                        else
                        begin
                            nxt.year  = {{(YEAR_W-4){1'b0}}, digit};
                            nxt.phase = PH_YDIG;
                        end
                    end
                    else
                        nxt.phase = PH_HUNT;
                end
            end
            PH_MSIGN:
            begin
                if (is_dig)
                begin
                    nxt.month = {3'b0, digit};
                    nxt.phase = PH_MDIG;
                end
                else
                    nxt.phase = PH_HUNT;
            end
            PH_YSIGN:
            begin
                if (is_dig)
                begin
                    nxt.year  = {{(YEAR_W-4){1'b0}}, digit};
                    nxt.phase = PH_YDIG;
                end
                else
                    nxt.phase = PH_HUNT;
            end
            PH_MDIG:
            begin
                if (is_dig)
                    nxt.month = acc_small(cur.month, digit);
                else if (ch == CH_DOT && !cur.neg && cur.month != '0
                         && cur.month <= MONTH_MAX)
                begin
                    nxt.phase = PH_YPRE;
                    nxt.neg   = 1'b0;
                    nxt.year  = '0;
                end
                else
                    nxt.phase = PH_HUNT;
            end
            PH_YDIG:
            begin
                if (is_dig)
                    nxt.year = acc_year(cur.year, digit);
                else
                begin
                    found     = year_ok(cur.neg, cur.year);
                    nxt.phase = PH_HUNT;
                end
            end
        endcase

        // The end of the stream closes a date whose year digits are still running.
        if (!found && last && nxt.phase == PH_YDIG)
            found = year_ok(nxt.neg, nxt.year);
    end

endmodule

@@ sv/latest_date_text_scanner_core.sv @@
// Scans a text stream one byte per beat for dates written as day.month.year, reports each
// date as it completes and keeps the latest one seen, which is also reported on the beat
// carrying the last byte; after that beat scan and maximum state reset for the next stream.
// A byte is taken every cycle: parsing and the running maximum are one short stage between
// the scan state registers and a result register, and a new byte is accepted while a result
// is still waiting as long as the consumer takes it in that same cycle.
module latest_date_text_scanner_core
    import ldts_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        ch,
    input  logic              last,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              date_found,
    output logic [4:0]        found_day,
    output logic [3:0]        found_month,
    output logic [YEAR_W-1:0] found_year,
    output logic              max_valid,
    output logic [4:0]        max_day,
    output logic [3:0]        max_month,
    output logic [YEAR_W-1:0] max_year,
    output logic              final_res
);

    scan_t             scan_reg;
    scan_t             scan_next;
    scan_t             parsed;
    logic              found;
    logic              in_fire;
    logic              newer;
    logic              best_valid_reg, best_valid_next;
    logic [4:0]        best_day_reg, best_day_next;
    logic [3:0]        best_month_reg, best_month_next;
    logic [YEAR_W-1:0] best_year_reg, best_year_next;
    logic              out_valid_reg;
    logic              date_found_reg;
    logic [4:0]        found_day_reg;
    logic [3:0]        found_month_reg;
    logic [YEAR_W-1:0] found_year_reg;
    logic              max_valid_reg;
    logic [4:0]        max_day_reg;
    logic [3:0]        max_month_reg;
    logic [YEAR_W-1:0] max_year_reg;
    logic              final_res_reg;

    ldts_parse u_parse (
        .ch    (ch),
        .last  (last),
        .cur   (scan_reg),
        .nxt   (parsed),
        .found (found)
    );

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    assign newer = !best_valid_reg
                || parsed.year > best_year_reg
                || (parsed.year == best_year_reg
                    && (parsed.month[3:0] > best_month_reg
                        || (parsed.month[3:0] == best_month_reg
                            && parsed.day[4:0] > best_day_reg)));

    always_comb
    begin
        best_valid_next = best_valid_reg;
        best_day_next   = best_day_reg;
        best_month_next = best_month_reg;
        best_year_next  = best_year_reg;
        if (found && newer)
        begin
            best_valid_next = 1'b1;
            best_day_next   = parsed.day[4:0];
            best_month_next = parsed.month[3:0];
            best_year_next  = parsed.year;
        end
        scan_next = last ? SCAN_RESET : parsed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg       <= SCAN_RESET;
            best_valid_reg <= 1'b0;
            best_day_reg   <= '0;
            best_month_reg <= '0;
            best_year_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                scan_reg <= scan_next;
                if (last)
                begin
                    best_valid_reg <= 1'b0;
                    best_day_reg   <= '0;
                    best_month_reg <= '0;
                    best_year_reg  <= '0;
                end
                else
                begin
                    best_valid_reg <= best_valid_next;
                    best_day_reg   <= best_day_next;
                    best_month_reg <= best_month_next;
                    best_year_reg  <= best_year_next;
                end
            end
            if (in_fire && (found || last))
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && (found || last))
        begin
            date_found_reg  <= found;
            found_day_reg   <= found ? parsed.day[4:0] : 5'd0;
            found_month_reg <= found ? parsed.month[3:0] : 4'd0;
            found_year_reg  <= found ? parsed.year : '0;
            max_valid_reg   <= best_valid_next;
            max_day_reg     <= best_day_next;
            max_month_reg   <= best_month_next;
            max_year_reg    <= best_year_next;
            final_res_reg   <= last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign date_found  = date_found_reg;
    assign found_day   = found_day_reg;
    assign found_month = found_month_reg;
    assign found_year  = found_year_reg;
    assign max_valid   = max_valid_reg;
    assign max_day     = max_day_reg;
    assign max_month   = max_month_reg;
    assign max_year    = max_year_reg;
    assign final_res   = final_res_reg;

    a_found_sets_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && date_found |-> max_valid && max_year >= found_year)
        else $error("A reported date is missing from the kept maximum.");

    a_found_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && date_found |-> found_day != 5'd0 && found_month != 4'd0
            && found_month <= 4'd12 && found_year != '0)
        else $error("A reported date has a field out of range.");

    a_max_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && max_valid |-> max_day != 5'd0 && max_month != 4'd0
            && max_month <= 4'd12 && max_year != '0)
        else $error("The kept maximum has a field out of range.");

    a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && last |=> scan_reg.phase == PH_HUNT && !best_valid_reg)
        else $error("State was not cleared after the last byte.");

endmodule
